>>> rtl/bscl_pkg.sv
package bscl_pkg;

    // item operations
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_STOP    = 3'd2;
    localparam logic [2:0] OP_RELEASE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_HALL    = 3'd5;
    localparam logic [2:0] OP_SETCMD  = 3'd6;

    // motor states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_BRAKE = 3'd2;
    localparam logic [2:0] ST_REV   = 3'd3;
    localparam logic [2:0] ST_FAULT = 3'd4;

    // fault codes
    localparam logic [1:0] FLT_NONE = 2'd0;
    localparam logic [1:0] FLT_OC   = 2'd1;
    localparam logic [1:0] FLT_HALL = 2'd2;

    // drive actions
    localparam logic [2:0] ACT_NONE   = 3'd0;
    localparam logic [2:0] ACT_DRIVE  = 3'd1;
    localparam logic [2:0] ACT_COAST  = 3'd2;
    localparam logic [2:0] ACT_FBRAKE = 3'd3;
    localparam logic [2:0] ACT_COMM   = 3'd4;

    // config register indexes
    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_TLIM   = 3'd1;
    localparam logic [2:0] CFG_HLIM   = 3'd2;
    localparam logic [2:0] CFG_WARN   = 3'd3;
    localparam logic [2:0] CFG_STALL  = 3'd4;
    localparam logic [2:0] CFG_BREL   = 3'd5;
    localparam logic [2:0] CFG_BENT   = 3'd6;
    localparam logic [2:0] CFG_BCOAST = 3'd7;

    localparam logic [1:0] MODE_VEL = 2'd1;
    localparam logic [1:0] MODE_POS = 2'd2;

    // signed duty width (PWM maximum up to 4095)
    localparam int DW = 13;
    // divider dividend width
    localparam int DIV_NW = 32;

    localparam int PWM_MAX_DEF       = 4095;
    localparam int BRAKE_DUTY_DEF    = 512;
    localparam int RPM_NUMERATOR_DEF = 4000000;

    typedef struct packed {
        logic ld_in;
        logic op_exec;
        logic tick_a;
        logic tick_b;
        logic trim_go;
        logic tick_c;
        logic ld_out;
    } bscl_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic div_busy;
        logic b_trim;
        logic b_done;
    } bscl_sts_t;

endpackage

>>> rtl/bldc_supervisor_current_limiter.sv
// Brushless motor supervisor with current limiting. Every accepted word
// (tick or command) gives exactly one result word. A command is executed
// in the dispatch state and its result then loaded. A tick starts a speed
// divide, then runs fault and state checks; it goes straight to its result
// when it ends in a fault, idle, brake or reversal, passes through the drive
// phase when it drives, and runs a second divide before the drive phase when
// the current limiter trims the duty. Both divides use the shared 32-step
// bit-serial divider that first computes speed from the hall period and
// then scales the duty by the current ratio. The next word is taken in the
// cycle after the result is loaded, and a result may first wait for an
// earlier one to be taken. One word is processed at a time; a new word is
// taken while the previous result waits in the output register.
// Configuration writes are taken every cycle and must come only while idle.
module bldc_supervisor_current_limiter import bscl_pkg::*; #(
    parameter int PWM_MAX       = PWM_MAX_DEF,
    parameter int BRAKE_DUTY    = BRAKE_DUTY_DEF,
    parameter int RPM_NUMERATOR = RPM_NUMERATOR_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic signed [15:0] s_command_value,
    input  logic signed [15:0] s_controller_duty,
    input  logic [2:0]         s_hall_code,
    input  logic [15:0]        s_hall_period_ticks,
    input  logic signed [1:0]  s_hall_dir,
    input  logic [15:0]        s_shunt_current_ma,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_motor_state_out,
    output logic [1:0]         m_fault_out,
    output logic [2:0]         m_drive_action,
    output logic signed [1:0]  m_drive_direction,
    output logic [11:0]        m_drive_duty,
    output logic               m_pwm_enable,
    output logic signed [15:0] m_velocity_rpm_out,
    output logic [15:0]        m_filtered_current_out
);

    bscl_cmd_t cmd;
    bscl_sts_t sts;

    assign cfg_ready = 1'b1;

    bscl_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    bscl_dp #(
        .PWM_MAX      (PWM_MAX),
        .BRAKE_DUTY   (BRAKE_DUTY),
        .RPM_NUMERATOR(RPM_NUMERATOR)
    ) u_dp (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .sts                   (sts),
        .cfg_valid             (cfg_valid),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_op                  (s_op),
        .s_command_value       (s_command_value),
        .s_controller_duty     (s_controller_duty),
        .s_hall_code           (s_hall_code),
        .s_hall_period_ticks   (s_hall_period_ticks),
        .s_hall_dir            (s_hall_dir),
        .s_shunt_current_ma    (s_shunt_current_ma),
        .m_motor_state_out     (m_motor_state_out),
        .m_fault_out           (m_fault_out),
        .m_drive_action        (m_drive_action),
        .m_drive_direction     (m_drive_direction),
        .m_drive_duty          (m_drive_duty),
        .m_pwm_enable          (m_pwm_enable),
        .m_velocity_rpm_out    (m_velocity_rpm_out),
        .m_filtered_current_out(m_filtered_current_out)
    );

endmodule

>>> rtl/bscl_div.sv
module bscl_div import bscl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [15:0]       den,
    output logic              busy,
    output logic [DIV_NW-1:0] quo
);

    localparam int CW = $clog2(DIV_NW);

    logic [15:0]       rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [15:0]       den_reg, den_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [16:0]       rem_sh;
    logic [16:0]       diff;
    logic              ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[DIV_NW-1]};
        diff      = rem_sh - {1'b0, den_reg};
        ge        = rem_sh >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = CW'(DIV_NW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[15:0] : rem_sh[15:0];
            quo_next = {quo_reg[DIV_NW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/bscl_ctrl.sv
module bscl_ctrl import bscl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bscl_sts_t sts,
    output bscl_cmd_t cmd
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_DISP = 3'd1;
    localparam logic [2:0] C_DIV1 = 3'd2;
    localparam logic [2:0] C_B    = 3'd3;
    localparam logic [2:0] C_MUL  = 3'd4;
    localparam logic [2:0] C_DIV2 = 3'd5;
    localparam logic [2:0] C_C    = 3'd6;
    localparam logic [2:0] C_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;
    logic       out_free;

    assign out_free = !mv_reg || m_ready;
    assign s_ready  = (state_reg == C_IDLE);
    assign m_valid  = mv_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            C_IDLE: begin
                if (s_valid) begin
                    cmd.ld_in  = 1'b1;
                    state_next = C_DISP;
                end
            end
            C_DISP: begin
                if (sts.is_tick) begin
                    cmd.tick_a = 1'b1;
                    state_next = C_DIV1;
                end else begin
                    cmd.op_exec = 1'b1;
                    state_next  = C_DONE;
                end
            end
            C_DIV1: begin
                if (!sts.div_busy) begin
                    state_next = C_B;
                end
            end
            C_B: begin
                cmd.tick_b = 1'b1;
                if (sts.b_trim) begin
                    state_next = C_MUL;
                end else if (sts.b_done) begin
                    state_next = C_DONE;
                end else begin
                    state_next = C_C;
                end
            end
            C_MUL: begin
                cmd.trim_go = 1'b1;
                state_next  = C_DIV2;
            end
            C_DIV2: begin
                if (!sts.div_busy) begin
                    state_next = C_C;
                end
            end
            C_C: begin
                cmd.tick_c = 1'b1;
                state_next = C_DONE;
            end
            C_DONE: begin
                if (out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    // result word valid
    always_comb begin
        mv_next = mv_reg;
        if (cmd.ld_out) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

endmodule

>>> rtl/bscl_dp.sv
module bscl_dp import bscl_pkg::*; #(
    parameter int PWM_MAX       = PWM_MAX_DEF,
    parameter int BRAKE_DUTY    = BRAKE_DUTY_DEF,
    parameter int RPM_NUMERATOR = RPM_NUMERATOR_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  bscl_cmd_t          cmd,
    output bscl_sts_t          sts,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [2:0]         s_op,
    input  logic signed [15:0] s_command_value,
    input  logic signed [15:0] s_controller_duty,
    input  logic [2:0]         s_hall_code,
    input  logic [15:0]        s_hall_period_ticks,
    input  logic signed [1:0]  s_hall_dir,
    input  logic [15:0]        s_shunt_current_ma,
    output logic [2:0]         m_motor_state_out,
    output logic [1:0]         m_fault_out,
    output logic [2:0]         m_drive_action,
    output logic signed [1:0]  m_drive_direction,
    output logic [11:0]        m_drive_duty,
    output logic               m_pwm_enable,
    output logic signed [15:0] m_velocity_rpm_out,
    output logic [15:0]        m_filtered_current_out
);

    localparam int UP_I  = (PWM_MAX / 128 == 0) ? 1 : PWM_MAX / 128;
    localparam int DN_I  = (PWM_MAX / 64 == 0) ? 1 : PWM_MAX / 64;
    localparam int DNF_I = (PWM_MAX / 32 == 0) ? 1 : PWM_MAX / 32;
    localparam logic signed [DW-1:0] UP_S   = DW'(UP_I);
    localparam logic signed [DW-1:0] DN_S   = DW'(DN_I);
    localparam logic signed [DW-1:0] DNF_S  = DW'(DNF_I);
    localparam logic signed [DW-1:0] PMAX_S = DW'(PWM_MAX);
    localparam logic signed [DW-1:0] CAP_S  = DW'(PWM_MAX / 4);
    localparam logic signed [DW-1:0] BRK_S  = DW'(BRAKE_DUTY);
    localparam logic signed [15:0]   PMAX16 = 16'(PWM_MAX);
    localparam logic [1:0] DIR_POS = 2'b01;
    localparam logic [1:0] DIR_NEG = 2'b11;

    // config registers
    logic [1:0]  mode_reg;
    logic [15:0] tl_reg, hl_reg, warn_reg, to_reg, brel_reg, bent_reg, bcoast_reg;

    // latched item
    logic [2:0]         op_reg;
    logic signed [15:0] cv_reg, cd_reg;
    logic [2:0]         hall_reg;
    logic [15:0]        per_reg, cur_reg;
    logic [1:0]         hdir_reg;

    // motor state
    logic [2:0]          st_reg, st_next;
    logic [1:0]          fc_reg, fc_next;
    logic [15:0]         sc_reg, sc_next;
    logic [2:0]          last_reg, last_next;
    logic [15:0]         cf_reg, cf_next;
    logic signed [DW-1:0] ad_reg, ad_next;
    logic                tsn_reg, tsn_next;
    logic signed [15:0]  tod_reg, tod_next;
    logic                pwm_reg, pwm_next;

    // item result
    logic [2:0]         act_reg, act_next;
    logic [1:0]         dir_reg, dir_next;
    logic [11:0]        rd_reg, rd_next;
    logic signed [15:0] vel_reg, vel_next;

    // tick work registers
    logic                 spd_ok_reg, spd_ok_next;
    logic signed [DW-1:0] lim_reg, lim_next;
    logic signed [DW-1:0] up_reg, up_next, dn_reg, dn_next;
    logic                 trim_reg, trim_next, tneg_reg, tneg_next, tz_reg, tz_next;
    logic [27:0]          prod_reg, prod_next;
    logic [15:0]          tden_reg, tden_next;

    // divider port
    logic              div_start, div_busy;
    logic [DIV_NW-1:0] div_num, div_quo;
    logic [15:0]       div_den;

    // shared combinational terms
    logic        adir_neg, adir_zero, stalled, ae_neg, ae_zero, flt;
    logic [14:0] spd;
    logic [15:0] absv;
    logic        bdir_neg, bdir_zero;
    logic [2:0]  brk_act;
    logic [1:0]  brk_dir;
    logic [11:0] brk_duty;
    logic signed [DW-1:0] brk_ad;
    logic [17:0] filt_sum;
    logic signed [15:0] raw;
    logic signed [DW-1:0] duty_c;
    logic [13:0] band0;
    logic [15:0] band, soft_ma;
    logic [11:0] ad_mag;
    logic        rev_go;

    // phase C terms
    logic signed [DW-1:0] tq, tt, lim, dsel, step, capd;
    logic signed [DW+1:0] nx;
    logic [DW-2:0]        cmag, gmag;

    assign sts.is_tick  = (op_reg == OP_TICK);
    assign sts.div_busy = div_busy;

    bscl_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .busy   (div_busy),
        .quo    (div_quo)
    );

    assign div_start = cmd.tick_a || cmd.trim_go;
    assign div_num   = cmd.trim_go ? DIV_NW'(prod_reg) : DIV_NW'(RPM_NUMERATOR);
    assign div_den   = cmd.trim_go ? tden_reg : per_reg;

    // direction, speed, stall, fault and filter view of the current item
    always_comb begin
        adir_neg  = hdir_reg[1];
        adir_zero = (hdir_reg == 2'b00);
        stalled   = sc_reg > to_reg;
        ae_neg    = adir_neg && !stalled;
        ae_zero   = adir_zero || stalled;
        spd       = !spd_ok_reg ? 15'd0 : ((|div_quo[DIV_NW-1:15]) ? 15'h7FFF : div_quo[14:0]);
        absv      = stalled ? 16'd0 : {1'b0, spd};
        flt       = (cur_reg > hl_reg) || (hall_reg == 3'd0) || (hall_reg == 3'd7);
        filt_sum  = {2'b00, cf_reg} + {1'b0, cf_reg, 1'b0} + {2'b00, cur_reg};
        ad_mag    = ad_reg[DW-1] ? 12'(-ad_reg) : 12'(ad_reg);
        // braking output
        bdir_neg  = sts.is_tick ? ae_neg : adir_neg;
        bdir_zero = sts.is_tick ? ae_zero : adir_zero;
        if (bdir_zero || cf_reg >= bcoast_reg) begin
            brk_act  = ACT_COAST;
            brk_dir  = 2'b00;
            brk_duty = 12'd0;
            brk_ad   = '0;
        end else begin
            brk_act  = ACT_DRIVE;
            brk_dir  = bdir_neg ? DIR_POS : DIR_NEG;
            brk_duty = 12'(BRAKE_DUTY);
            brk_ad   = bdir_neg ? BRK_S : -BRK_S;
        end
        // commanded duty and limit band
        raw = (mode_reg == MODE_VEL || mode_reg == MODE_POS) ? cd_reg : tod_reg;
        if (raw > PMAX16) begin
            duty_c = PMAX_S;
        end else if (raw < -PMAX16) begin
            duty_c = -PMAX_S;
        end else begin
            duty_c = raw[DW-1:0];
        end
        band0 = tl_reg[15:2];
        if (band0 < 14'd100) begin
            band = 16'd100;
        end else if (band0 > 14'd1000) begin
            band = 16'd1000;
        end else begin
            band = {2'b00, band0};
        end
        soft_ma = (tl_reg > band) ? tl_reg - band : 16'd0;
        rev_go  = (mode_reg == MODE_VEL || mode_reg == MODE_POS) && !ae_zero &&
                  (ae_neg != tsn_reg) && (absv > bent_reg);
    end

    // phase C: trimmed target, slew, stall cap
    always_comb begin
        tq = div_quo[DW-1:0];
        tt = tneg_reg ? -tq : tq;
        if (tz_reg) begin
            tt = '0;
        end
        if (tt == ad_reg) begin
            if (tt > 0) begin
                tt = tt - 1'b1;
            end else if (tt < 0) begin
                tt = tt + 1'b1;
            end
        end
        lim  = trim_reg ? tt : lim_reg;
        cmag = ad_reg[DW-1] ? (DW-1)'(-ad_reg) : (DW-1)'(ad_reg);
        gmag = lim[DW-1] ? (DW-1)'(-lim) : (DW-1)'(lim);
        if ((ad_reg > 0 && lim < 0) || (ad_reg < 0 && lim > 0)) begin
            step = dn_reg;
        end else if (gmag > cmag) begin
            step = up_reg;
        end else begin
            step = dn_reg;
        end
        if (ad_reg == lim) begin
            nx   = (DW+2)'(ad_reg);
            dsel = ad_reg;
        end else if (ad_reg < lim) begin
            nx   = (DW+2)'(ad_reg) + (DW+2)'(step);
            dsel = (nx > (DW+2)'(lim)) ? lim : nx[DW-1:0];
        end else begin
            nx   = (DW+2)'(ad_reg) - (DW+2)'(step);
            dsel = (nx < (DW+2)'(lim)) ? lim : nx[DW-1:0];
        end
        capd = dsel;
        if (sc_reg >= to_reg) begin
            if (dsel > CAP_S) begin
                capd = CAP_S;
            end else if (dsel < -CAP_S) begin
                capd = -CAP_S;
            end
        end
    end

    // next-state logic for all item phases
    always_comb begin
        st_next = st_reg;   fc_next = fc_reg;   sc_next = sc_reg;
        last_next = last_reg; cf_next = cf_reg; ad_next = ad_reg;
        tsn_next = tsn_reg; tod_next = tod_reg; pwm_next = pwm_reg;
        act_next = act_reg; dir_next = dir_reg; rd_next = rd_reg; vel_next = vel_reg;
        spd_ok_next = spd_ok_reg; lim_next = lim_reg; up_next = up_reg; dn_next = dn_reg;
        trim_next = trim_reg; tneg_next = tneg_reg; tz_next = tz_reg;
        prod_next = prod_reg; tden_next = tden_reg;
        sts.b_trim = 1'b0;
        sts.b_done = 1'b0;

        if (cmd.ld_in) begin
            act_next = ACT_NONE;
            dir_next = 2'b00;
            rd_next  = 12'd0;
            vel_next = '0;
        end

        // commands, executed in the dispatch state
        if (cmd.op_exec) begin
            unique case (op_reg)
                OP_START: begin
                    if (st_reg != ST_FAULT) begin
                        fc_next   = FLT_NONE;
                        sc_next   = 16'd0;
                        last_next = hall_reg;
                        st_next   = ST_RUN;
                        act_next  = ACT_COMM;
                        dir_next  = tsn_reg ? DIR_NEG : DIR_POS;
                        pwm_next  = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (st_reg != ST_IDLE && st_reg != ST_FAULT) begin
                        st_next = ST_BRAKE;
                    end
                end
                OP_RELEASE, OP_CLEAR: begin
                    if (op_reg == OP_CLEAR) begin
                        fc_next = FLT_NONE;
                    end
                    ad_next  = '0;
                    act_next = ACT_COAST;
                    pwm_next = 1'b0;
                    st_next  = ST_IDLE;
                end
                OP_HALL: begin
                    if (st_reg == ST_RUN) begin
                        act_next = ACT_COMM;
                        dir_next = tsn_reg ? DIR_NEG : DIR_POS;
                    end else if (st_reg == ST_BRAKE || st_reg == ST_REV) begin
                        act_next = brk_act;
                        dir_next = brk_dir;
                        rd_next  = brk_duty;
                        ad_next  = brk_ad;
                    end
                end
                OP_SETCMD: begin
                    tod_next = cv_reg;
                    tsn_next = cv_reg[15];
                end
                default: begin
                end
            endcase
        end

        // tick phase A: filter, stall count, start speed divide
        if (cmd.tick_a) begin
            cf_next = (cf_reg == 16'd0) ? cur_reg : filt_sum[17:2];
            if (hall_reg == last_reg) begin
                if (sc_reg != 16'hFFFF) begin
                    sc_next = sc_reg + 1'b1;
                end
            end else begin
                last_next = hall_reg;
                sc_next   = 16'd0;
            end
            spd_ok_next = (per_reg != 16'd0) && (per_reg != 16'hFFFF);
        end

        // tick phase B: faults and state machine
        if (cmd.tick_b) begin
            vel_next  = stalled ? 16'sd0 : (adir_neg ? -$signed({1'b0, spd}) : {1'b0, spd});
            trim_next = 1'b0;
            if (flt) begin
                st_next    = ST_FAULT;
                fc_next    = (cur_reg > hl_reg) ? FLT_OC : FLT_HALL;
                act_next   = ACT_FBRAKE;
                sts.b_done = 1'b1;
            end else begin
                if (st_reg == ST_RUN && stalled && cf_reg > warn_reg) begin
                    sc_next = to_reg;
                end
                if (st_reg == ST_BRAKE) begin
                    sts.b_done = 1'b1;
                    if (absv < brel_reg || ae_zero) begin
                        ad_next  = '0;
                        act_next = ACT_COAST;
                        pwm_next = 1'b0;
                        st_next  = ST_IDLE;
                    end else begin
                        act_next = brk_act; dir_next = brk_dir;
                        rd_next  = brk_duty; ad_next = brk_ad;
                    end
                end else if (st_reg == ST_IDLE || st_reg == ST_FAULT) begin
                    sts.b_done = 1'b1;
                end else if (st_reg == ST_REV && !(absv < brel_reg || ae_zero)) begin
                    sts.b_done = 1'b1;
                    act_next = brk_act; dir_next = brk_dir;
                    rd_next  = brk_duty; ad_next = brk_ad;
                end else begin
                    // running, possibly just released from reversing
                    if (st_reg == ST_REV) begin
                        sc_next = 16'd0;
                        st_next = ST_RUN;
                    end
                    if (rev_go) begin
                        sts.b_done = 1'b1;
                        st_next  = ST_REV;
                        act_next = brk_act; dir_next = brk_dir;
                        rd_next  = brk_duty; ad_next = brk_ad;
                    end else begin
                        lim_next  = duty_c;
                        up_next   = UP_S;
                        dn_next   = DN_S;
                        tneg_next = ad_reg[DW-1];
                        prod_next = ad_mag * tl_reg;
                        if (cur_reg >= tl_reg && ad_reg != 0) begin
                            trim_next  = 1'b1;
                            sts.b_trim = 1'b1;
                            tden_next  = cur_reg;
                            tz_next    = (cur_reg == 16'd0);
                            dn_next    = DNF_S;
                        end else if (cf_reg >= tl_reg && ad_reg != 0) begin
                            trim_next  = 1'b1;
                            sts.b_trim = 1'b1;
                            tden_next  = cf_reg;
                            tz_next    = (cf_reg == 16'd0);
                        end else if (cf_reg > soft_ma) begin
                            up_next = DW'(1);
                        end
                    end
                end
            end
        end

        // tick phase C: drive with slewed duty
        if (cmd.tick_c) begin
            tsn_next = capd[DW-1];
            ad_next  = capd;
            act_next = ACT_DRIVE;
            dir_next = capd[DW-1] ? DIR_NEG : DIR_POS;
            rd_next  = capd[DW-1] ? 12'(-capd) : 12'(capd);
        end
    end

    // config writes, item latch, state and output word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= 2'd0;
            tl_reg     <= 16'd10000;
            hl_reg     <= 16'd10000;
            warn_reg   <= 16'd5000;
            to_reg     <= 16'd200;
            brel_reg   <= 16'd100;
            bent_reg   <= 16'd200;
            bcoast_reg <= 16'd3000;
            st_reg     <= ST_IDLE;
            fc_reg     <= FLT_NONE;
            sc_reg     <= 16'd0;
            last_reg   <= 3'd0;
            cf_reg     <= 16'd0;
            ad_reg     <= '0;
            tsn_reg    <= 1'b0;
            tod_reg    <= '0;
            pwm_reg    <= 1'b0;
            op_reg     <= OP_TICK;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    CFG_TLIM:   tl_reg     <= (cfg_data > hl_reg) ? hl_reg : cfg_data;
                    CFG_HLIM:   hl_reg     <= cfg_data;
                    CFG_WARN:   warn_reg   <= cfg_data;
                    CFG_STALL:  to_reg     <= cfg_data;
                    CFG_BREL:   brel_reg   <= cfg_data;
                    CFG_BENT:   bent_reg   <= cfg_data;
                    CFG_BCOAST: bcoast_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            st_reg   <= st_next;
            fc_reg   <= fc_next;
            sc_reg   <= sc_next;
            last_reg <= last_next;
            cf_reg   <= cf_next;
            ad_reg   <= ad_next;
            tsn_reg  <= tsn_next;
            tod_reg  <= tod_next;
            pwm_reg  <= pwm_next;
            if (cmd.ld_in) begin
                op_reg <= s_op;
            end
        end
        if (cmd.ld_in) begin
            cv_reg   <= s_command_value;
            cd_reg   <= s_controller_duty;
            hall_reg <= s_hall_code;
            per_reg  <= s_hall_period_ticks;
            hdir_reg <= s_hall_dir;
            cur_reg  <= s_shunt_current_ma;
        end
        act_reg    <= act_next;
        dir_reg    <= dir_next;
        rd_reg     <= rd_next;
        vel_reg    <= vel_next;
        spd_ok_reg <= spd_ok_next;
        lim_reg    <= lim_next;
        up_reg     <= up_next;
        dn_reg     <= dn_next;
        trim_reg   <= trim_next;
        tneg_reg   <= tneg_next;
        tz_reg     <= tz_next;
        prod_reg   <= prod_next;
        tden_reg   <= tden_next;
        if (cmd.ld_out) begin
            m_motor_state_out      <= st_reg;
            m_fault_out            <= fc_reg;
            m_drive_action         <= act_reg;
            m_drive_direction      <= dir_reg;
            m_drive_duty           <= rd_reg;
            m_pwm_enable           <= pwm_reg;
            m_velocity_rpm_out     <= vel_reg;
            m_filtered_current_out <= cf_reg;
        end
    end

endmodule
